>>> rtl/tau_candidate_cut_counter_unit_macros.svh
// Assertion macros shared by the tau candidate cut counter RTL.
// They expect clk and arst_n in the scope of the module that uses them.
`ifndef TAU_CANDIDATE_CUT_COUNTER_UNIT_MACROS_SVH
`define TAU_CANDIDATE_CUT_COUNTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tccc_pkg.sv
// Shared types and constants of the tau candidate cut counter.
`default_nettype none
package tccc_pkg;

	// configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 60;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BARREL_COEFFS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENDCAP_COEFFS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_OFFLINE_PT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ETA_WINDOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_REL_ISO    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEAD_TRK   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT      = 3'd6;

	// default maximum candidates per event
	localparam int MAX_CANDS_DEF = 64;

	// words buffered between classifier and counter
	localparam int Q_DEPTH = 4;

	// |eta| below this selects the barrel coefficients (1.5 in 1/128 units)
	localparam logic signed [10:0] ETA_BARREL = 11'sd192;

	// isolation limit value that turns the cut off
	localparam logic [15:0] ISO_OFF = 16'hFFFF;

	// c0 = 0, c1 = 1.0 (Q.12), c2 = 0
	localparam logic [59:0] COEF_RESET = 60'h0_0001_0000_0000;

	typedef struct packed {
		logic [59:0]        barrel_coeffs;
		logic [59:0]        endcap_coeffs;
		logic signed [16:0] min_offline_pt;
		logic [23:0]        eta_window;
		logic [15:0]        max_rel_iso;
		logic signed [16:0] min_lead_track_pt;
		logic [6:0]         min_count;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		barrel_coeffs:     COEF_RESET,
		endcap_coeffs:     COEF_RESET,
		min_offline_pt:    -17'sd4,
		eta_window:        24'h280D80,
		max_rel_iso:       ISO_OFF,
		min_lead_track_pt: -17'sd4,
		min_count:         7'd1
	};

	// classified candidate word handed from front to back
	typedef struct packed {
		logic pass;
		logic last;
	} cls_t;

endpackage
`default_nettype wire

>>> rtl/tccc_cand_if.sv
// Candidate input channel.
`default_nettype none
interface tccc_cand_if;
	logic               valid;
	logic               ready;
	logic [15:0]        cand_pt;
	logic signed [10:0] cand_eta;
	logic [15:0]        iso_sum;
	logic [15:0]        track_pt;
	logic               end_of_event;

	modport source (output valid, cand_pt, cand_eta, iso_sum, track_pt, end_of_event,
		input ready);
	modport sink (input valid, cand_pt, cand_eta, iso_sum, track_pt, end_of_event,
		output ready);
endinterface
`default_nettype wire

>>> rtl/tccc_res_if.sv
// Result output channel.
`default_nettype none
interface tccc_res_if;
	logic       valid;
	logic       ready;
	logic       passed;
	logic [5:0] cand_index;
	logic [6:0] count_so_far;
	logic       accept;
	logic       final_res;

	modport source (output valid, passed, cand_index, count_so_far, accept, final_res,
		input ready);
	modport sink (input valid, passed, cand_index, count_so_far, accept, final_res,
		output ready);
endinterface
`default_nettype wire

>>> rtl/tccc_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface tccc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [59:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/tccc_front.sv
// Front end: takes candidates, calibrates pt and applies the cuts.
`default_nettype none
module tccc_front
	import tccc_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	tccc_cand_if.sink   cand,
	input  cfg_t        cfg,
	output logic        push,
	output cls_t        push_word,
	input  wire         q_ready
);

	typedef struct packed {
		logic signed [36:0] prod1;    // pt * c1
		logic [31:0]        sq;       // pt * pt
		logic [31:0]        iso_lim;  // max_rel_iso * pt
		logic [23:0]        iso_sh;   // iso_sum * 256
		logic signed [19:0] c0;
		logic signed [19:0] c2;
		logic               eta_ok;
		logic               trk_ok;
		logic               iso_dis;
		logic               pt_zero;
		logic               last;
	} st1_t;

	typedef struct packed {
		logic signed [52:0] term2;    // pt^2 * c2
		logic signed [45:0] sum01;    // c0 * 2^20 + pt * c1 * 2^8
		logic               eta_ok;
		logic               trk_ok;
		logic               iso_ok;
		logic               last;
	} st2_t;

	logic               v_s1, v_s2;
	st1_t               st_s1;
	st2_t               st_s2;
	logic               en;
	logic               barrel;
	logic [59:0]        coeffs;
	logic signed [19:0] c1;
	logic signed [16:0] pt_s;
	logic signed [11:0] eta12, emin, emax;
	st1_t               nx1;
	st2_t               nx2;
	logic signed [54:0] cal;
	logic signed [36:0] min_sc;
	logic               pt_ok;

	// whole pipe moves unless the last stage waits on the queue
	assign en        = !v_s2 || q_ready;
	assign cand.ready = en;

	// stage 1: coefficient select, first products, cheap cuts
	always_comb begin
		barrel = (cand.cand_eta > -ETA_BARREL) && (cand.cand_eta < ETA_BARREL);
		coeffs = barrel ? cfg.barrel_coeffs : cfg.endcap_coeffs;
		c1     = $signed(coeffs[39:20]);
		pt_s   = $signed({1'b0, cand.cand_pt});
		eta12  = 12'(cand.cand_eta);
		emin   = $signed(cfg.eta_window[11:0]);
		emax   = $signed(cfg.eta_window[23:12]);
		nx1.prod1   = 37'(pt_s) * 37'(c1);
		nx1.sq      = 32'(cand.cand_pt) * 32'(cand.cand_pt);
		nx1.iso_lim = 32'(cfg.max_rel_iso) * 32'(cand.cand_pt);
		nx1.iso_sh  = {cand.iso_sum, 8'b0};
		nx1.c0      = $signed(coeffs[19:0]);
		nx1.c2      = $signed(coeffs[59:40]);
		nx1.eta_ok  = (eta12 >= emin) && (eta12 <= emax);
		nx1.trk_ok  = $signed({1'b0, cand.track_pt}) > cfg.min_lead_track_pt;
		nx1.iso_dis = cfg.max_rel_iso == ISO_OFF;
		nx1.pt_zero = cand.cand_pt == 16'd0;
		nx1.last    = cand.end_of_event;
	end

	// stage 2: quadratic product, constant and linear terms, isolation compare
	always_comb begin
		nx2.term2  = 53'($signed({1'b0, st_s1.sq})) * 53'(st_s1.c2);
		nx2.sum01  = 46'($signed({st_s1.c0, 20'b0})) + 46'($signed({st_s1.prod1, 8'b0}));
		nx2.eta_ok = st_s1.eta_ok;
		nx2.trk_ok = st_s1.trk_ok;
		nx2.iso_ok = st_s1.iso_dis ||
			(!st_s1.pt_zero && ({8'b0, st_s1.iso_sh} < st_s1.iso_lim));
		nx2.last   = st_s1.last;
	end

	// final sum and pt threshold feed the queue
	always_comb begin
		cal    = 55'(st_s2.term2) + 55'(st_s2.sum01);
		min_sc = $signed({cfg.min_offline_pt, 20'b0});
		pt_ok  = cal >= 55'(min_sc);
		push_word.pass = pt_ok && st_s2.eta_ok && st_s2.iso_ok && st_s2.trk_ok;
		push_word.last = st_s2.last;
	end

	assign push = v_s2 && q_ready;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= cand.valid;
			v_s2 <= v_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nx1;
			st_s2 <= nx2;
		end
	end

endmodule
`default_nettype wire

>>> rtl/tccc_queue.sv
// Short word queue between the classifier and the event counter.
`default_nettype none
module tccc_queue
	import tccc_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	input  cls_t  push_word,
	output logic  q_ready,
	input  wire   pop,
	output logic  q_valid,
	output cls_t  q_word
);

	`include "tau_candidate_cut_counter_unit_macros.svh"

	localparam int PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CntW = $clog2(Q_DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Q_DEPTH - 1);
	localparam logic [CntW-1:0] Full    = CntW'(Q_DEPTH);

	cls_t            mem_q [Q_DEPTH];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;

	assign q_ready = count_q != Full;
	assign q_valid = count_q != '0;
	assign q_word  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TCCC_ASSERT_NOW(a_q_no_overflow, push, count_q != Full || pop, "queue overflow")
	`TCCC_ASSERT_NOW(a_q_no_underflow, pop, count_q != '0, "queue underflow")

endmodule
`default_nettype wire

>>> rtl/tccc_back.sv
// Back end: per-event counting and the registered result word.
`default_nettype none
module tccc_back
	import tccc_pkg::*;
#(
	parameter int MAX_CANDS = MAX_CANDS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         q_valid,
	input  cls_t        q_word,
	output logic        pop,
	input  logic [6:0]  min_count,
	tccc_res_if.source  res
);

	`include "tau_candidate_cut_counter_unit_macros.svh"

	localparam int PosCapI   = (MAX_CANDS - 1 > 63) ? 63 : MAX_CANDS - 1;
	localparam int CountCapI = (MAX_CANDS > 127) ? 127 : MAX_CANDS;
	localparam logic [5:0] PosCap   = 6'(PosCapI);
	localparam logic [6:0] CountCap = 7'(CountCapI);

	logic [5:0] pos_q;
	logic [6:0] cnt_q;
	logic [6:0] cnt_nx;
	logic       out_valid_q;
	logic       passed_q, accept_q, final_q;
	logic [5:0] index_q;
	logic [6:0] count_out_q;

	// take a word when the output register is free or being emptied
	assign pop = q_valid && (!out_valid_q || res.ready);

	assign cnt_nx = (q_word.pass && cnt_q < CountCap) ? cnt_q + 1'b1 : cnt_q;

	assign res.valid        = out_valid_q;
	assign res.passed       = passed_q;
	assign res.cand_index   = index_q;
	assign res.count_so_far = count_out_q;
	assign res.accept       = accept_q;
	assign res.final_res    = final_q;

	// event state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (q_word.last) begin
					pos_q <= '0;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_nx;
					if (pos_q < PosCap) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (pop) begin
			passed_q    <= q_word.pass;
			index_q     <= pos_q;
			count_out_q <= cnt_nx;
			accept_q    <= q_word.last && (cnt_nx >= min_count);
			final_q     <= q_word.last;
		end
	end

	`TCCC_ASSERT_NOW(a_accept_only_final, out_valid_q && accept_q, final_q,
		"accept without final flag")
	`TCCC_ASSERT_NEXT(a_clear_after_last, pop && q_word.last, pos_q == '0 && cnt_q == '0,
		"event state not cleared")
	`TCCC_ASSERT_NOW(a_count_capped, 1'b1, cnt_q <= CountCap && pos_q <= PosCap,
		"counter beyond cap")

endmodule
`default_nettype wire

>>> rtl/tau_candidate_cut_counter_unit.sv
// Tau candidate cut counter: calibrates and cuts each candidate word and counts
// passing candidates per event. One candidate word is accepted per clock unless the
// second calibration stage holds a word that the full four-word queue cannot take.
// An accepted word passes the stage 1 and stage 2 registers and the queue before the
// output register. Two calibration stages (pt*c1 and pt*pt, then pt^2*c2) are followed
// by the final sum and cuts, which feed the queue write. The output register loads
// as the word leaves the queue. Result stalls fill the queue first and then
// hold the pipeline. Configuration writes are taken at any time with ready held high
// and are meant for an idle block; unknown register indexes are ignored. There is no
// clearing pass after reset.
`default_nettype none
module tau_candidate_cut_counter_unit
	import tccc_pkg::*;
#(
	parameter int MAX_CANDS = MAX_CANDS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	tccc_cand_if.sink   cand,
	tccc_res_if.source  res,
	tccc_cfg_if.sink    cfg
);

	cfg_t cfg_q;
	logic push, q_ready, pop, q_valid;
	cls_t push_word, q_word;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_BARREL_COEFFS:  cfg_q.barrel_coeffs     <= cfg.data[59:0];
				REG_ENDCAP_COEFFS:  cfg_q.endcap_coeffs     <= cfg.data[59:0];
				REG_MIN_OFFLINE_PT: cfg_q.min_offline_pt    <= $signed(cfg.data[16:0]);
				REG_ETA_WINDOW:     cfg_q.eta_window        <= cfg.data[23:0];
				REG_MAX_REL_ISO:    cfg_q.max_rel_iso       <= cfg.data[15:0];
				REG_MIN_LEAD_TRK:   cfg_q.min_lead_track_pt <= $signed(cfg.data[16:0]);
				REG_MIN_COUNT:      cfg_q.min_count         <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	tccc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cand      (cand),
		.cfg       (cfg_q),
		.push      (push),
		.push_word (push_word),
		.q_ready   (q_ready)
	);

	tccc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.q_ready   (q_ready),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_word    (q_word)
	);

	tccc_back #(
		.MAX_CANDS (MAX_CANDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.pop       (pop),
		.min_count (cfg_q.min_count),
		.res       (res)
	);

endmodule
`default_nettype wire
